// ===== hw/rtl/vlfd_pkg.sv =====
package vlfd_pkg;

    localparam int unsigned FIELD_W = 20;
    localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};
    localparam logic [FIELD_W-1:0] MAX_FRAME_RESET = 20'd16384;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // result word as it travels through the queue
    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         frame_type;
        logic [7:0]         payload_byte;
        logic [FIELD_W-1:0] payload_length;
        logic               last;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

endpackage

// ===== hw/rtl/varint_length_frame_deframer.sv =====
// Varint length-prefixed frame splitter.
// Slave stream: one stream byte per word on s_axis_tdata.
// Config: i_cfg_wr writes i_cfg_data as max_frame_size (reset 16384); write only when idle.
// Master stream: one result word per payload byte; an empty frame gives one word on
// its type byte, an oversized frame one error word (tuser = 2), then all further
// bytes are dropped until reset.
// Throughput: one byte per cycle while the queue has space; the header parse and
// limit check sit in one front stage feeding a two-entry queue.
// A result is registered in the queue before it appears on m_axis.
// Reset: synchronous, active low; clears the parser and the queue, restores the limit.
// Stall: when m_axis_tready is low the queue holds up to two results, then
// s_axis_tready drops until the receiver takes a word.
module varint_length_frame_deframer #(
    parameter int LENGTH_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr,
    input  logic [19:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // frame_type, payload_byte, payload_length, pad
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last
);
    import vlfd_pkg::*;

    logic [19:0] r_max;
    logic        space, push;
    t_result     res, q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_FRAME_RESET;
        end else if (i_cfg_wr) begin
            r_max <= i_cfg_data;
        end
    end

    vlfd_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_max_frame_size(r_max),
        .i_valid(s_axis_tvalid), .i_byte(s_axis_tdata), .o_ready(s_axis_tready),
        .i_space(space), .o_push(push), .o_result(res)
    );

    vlfd_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(push), .i_data(res), .o_space(space),
        .o_valid(m_axis_tvalid), .o_data(q), .i_pop(m_axis_tready)
    );

    assign m_axis_tdata = {4'd0, q.payload_length, q.payload_byte, q.frame_type};
    assign m_axis_tuser = q.kind;
    assign m_axis_tlast = q.last;

    a_kind_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("bad kind");
    a_nondata_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tlast)
        else $error("empty or error word without last");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> m_axis_tdata[15:0] == 16'd0)
        else $error("error word carries type or data");

endmodule

// ===== hw/rtl/vlfd_front.sv =====
module vlfd_front #(
    parameter int LENGTH_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [19:0]              i_max_frame_size,
    input  logic                     i_valid,
    input  logic [7:0]               i_byte,
    output logic                     o_ready,
    input  logic                     i_space,
    output logic                     o_push,
    output vlfd_pkg::t_result        o_result
);
    import vlfd_pkg::*;

    localparam logic [2:0] PH_HDR_FIRST = 3'd0;
    localparam logic [2:0] PH_HDR_REST  = 3'd1;
    localparam logic [2:0] PH_TYPE      = 3'd2;
    localparam logic [2:0] PH_PAYLOAD   = 3'd3;
    localparam logic [2:0] PH_HALT      = 3'd4;

    logic [2:0]             r_phase, n_phase;
    logic [2:0]             r_left, n_left;
    logic [3:0]             r_hsize, n_hsize;
    logic [61:0]            r_accum, n_accum;
    logic [7:0]             r_type, n_type;
    logic [LENGTH_BITS-1:0] r_pleft, n_pleft;
    logic [LENGTH_BITS-1:0] r_flen, n_flen;

    logic        fire;
    logic [61:0] hdr_len;
    logic [3:0]  hdr_size;
    logic        hdr_done;
    logic [63:0] total;
    logic        too_big;
    logic [FIELD_W-1:0] len_sat;
    logic [FIELD_W-1:0] flen_out;

    assign o_ready = i_space;
    assign fire    = i_valid && i_space;

    always_comb begin
        hdr_len  = r_accum;
        hdr_size = r_hsize;
        hdr_done = 1'b0;
        if (r_phase == PH_HDR_FIRST) begin
            hdr_size = 4'd1 << i_byte[7:6];
            hdr_len  = {56'd0, i_byte[5:0]};
            hdr_done = (i_byte[7:6] == 2'd0);
        end else if (r_phase == PH_HDR_REST) begin
            hdr_len  = {r_accum[53:0], i_byte};
            hdr_done = (r_left == 3'd1);
        end
    end

    assign total   = {2'd0, hdr_len} + {60'd0, hdr_size} + 64'd1;
    assign too_big = total > {44'd0, i_max_frame_size};
    assign len_sat = (hdr_len > {42'd0, FIELD_MAX}) ? FIELD_MAX : hdr_len[FIELD_W-1:0];

    generate
        if (LENGTH_BITS >= FIELD_W) begin : g_wide
            assign flen_out = (r_flen > LENGTH_BITS'(FIELD_MAX)) ? FIELD_MAX
                            : r_flen[FIELD_W-1:0];
        end else begin : g_narrow
            assign flen_out = FIELD_W'(r_flen);
        end
    endgenerate

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_hsize  = r_hsize;
        n_accum  = r_accum;
        n_type   = r_type;
        n_pleft  = r_pleft;
        n_flen   = r_flen;
        o_push   = 1'b0;
        o_result = '0;
        if (fire) begin
            unique case (r_phase)
                PH_HDR_FIRST, PH_HDR_REST: begin
                    n_hsize = hdr_size;
                    n_accum = hdr_len;
                    n_left  = (r_phase == PH_HDR_FIRST) ? 3'(hdr_size - 4'd1)
                                                        : r_left - 3'd1;
                    if (hdr_done) begin
                        if (too_big) begin
                            o_push = 1'b1;
                            o_result.kind           = KIND_ERROR;
                            o_result.payload_length = len_sat;
                            o_result.last           = 1'b1;
                            n_phase = PH_HALT;
                        end else begin
                            n_flen  = hdr_len[LENGTH_BITS-1:0];
                            n_phase = PH_TYPE;
                        end
                    end else begin
                        n_phase = PH_HDR_REST;
                    end
                end
                PH_TYPE: begin
                    n_type = i_byte;
                    if (r_flen == '0) begin
                        o_push = 1'b1;
                        o_result.kind       = KIND_EMPTY;
                        o_result.frame_type = i_byte;
                        o_result.last       = 1'b1;
                        n_phase = PH_HDR_FIRST;
                    end else begin
                        n_pleft = r_flen;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_push = 1'b1;
                    o_result.kind           = KIND_DATA;
                    o_result.frame_type     = r_type;
                    o_result.payload_byte   = i_byte;
                    o_result.payload_length = flen_out;
                    o_result.last           = (r_pleft == LENGTH_BITS'(1));
                    n_pleft = r_pleft - LENGTH_BITS'(1);
                    if (r_pleft == LENGTH_BITS'(1)) begin
                        n_phase = PH_HDR_FIRST;
                    end
                end
                PH_HALT: begin
                    n_phase = PH_HALT;
                end
                default: begin
                    n_phase = PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR_FIRST;
            r_left  <= '0;
            r_hsize <= '0;
            r_accum <= '0;
            r_type  <= '0;
            r_pleft <= '0;
            r_flen  <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_hsize <= n_hsize;
            r_accum <= n_accum;
            r_type  <= n_type;
            r_pleft <= n_pleft;
            r_flen  <= n_flen;
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |=> r_phase == PH_HALT)
        else $error("halt state left");
    a_no_push_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |-> !o_push)
        else $error("result while halted");
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_space)
        else $error("push without queue space");

endmodule

// ===== hw/rtl/vlfd_queue.sv =====
module vlfd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  vlfd_pkg::t_result  i_data,
    output logic               o_space,
    output logic               o_valid,
    output vlfd_pkg::t_result  o_data,
    input  logic               i_pop
);
    import vlfd_pkg::*;

    // two-entry skid queue: full rate, registered ready
    t_result    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop)    r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count overflow");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 && !pop |-> !i_push)
        else $error("push into full queue");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("pointer mismatch");

endmodule

// ===== dv/varint_length_frame_deframer_tb.sv =====
module varint_length_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vlfd_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef enum logic [2:0] {
        PH_HDR_FIRST, PH_HDR_REST, PH_TYPE, PH_PAYLOAD, PH_HALT
    } t_phase;

    // Tracks the frame parser and holds the words it predicts.
    class frame_scoreboard;
        t_result     pending_words[$];
        logic [19:0] max_frame;
        t_phase      phase;
        int unsigned hdr_left;
        int unsigned hdr_size;
        logic [61:0] len_accum;
        logic [7:0]  cur_type;
        logic [19:0] payload_left;
        logic [19:0] frame_len;
        int          mismatches;

        function void clear();
            max_frame = MAX_FRAME_RESET;
            phase = PH_HDR_FIRST;
            hdr_left = 0; hdr_size = 0; len_accum = '0;
            cur_type = '0; payload_left = '0; frame_len = '0;
            mismatches = 0;
            pending_words.delete();
        endfunction

        function void push(logic [1:0] k, logic [7:0] t, logic [7:0] d,
                           logic [61:0] len, logic l);
            t_result r;
            r.kind = k; r.frame_type = t; r.payload_byte = d;
            r.payload_length = (len > 62'(FIELD_MAX)) ? FIELD_MAX : len[19:0];
            r.last = l;
            pending_words.push_back(r);
        endfunction

        function void header_complete();
            logic [63:0] total;
            total = 64'(len_accum) + 64'(hdr_size) + 64'd1;
            if (total > 64'(max_frame)) begin
                push(KIND_ERROR, 8'd0, 8'd0, len_accum, 1'b1);
                phase = PH_HALT;
            end else begin
                frame_len = len_accum[19:0];
                phase = PH_TYPE;
            end
        endfunction

        function void note_byte(logic [7:0] b);
            case (phase)
                PH_HDR_FIRST: begin
                    hdr_size = 1 << b[7:6];
                    len_accum = 62'(b[5:0]);
                    hdr_left = hdr_size - 1;
                    if (hdr_left == 0) header_complete();
                    else phase = PH_HDR_REST;
                end
                PH_HDR_REST: begin
                    len_accum = {len_accum[53:0], b};
                    hdr_left--;
                    if (hdr_left == 0) header_complete();
                end
                PH_TYPE: begin
                    cur_type = b;
                    if (frame_len == 0) begin
                        push(KIND_EMPTY, cur_type, 8'd0, 62'd0, 1'b1);
                        phase = PH_HDR_FIRST;
                    end else begin
                        payload_left = frame_len;
                        phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    push(KIND_DATA, cur_type, b, 62'(frame_len), payload_left == 1);
                    payload_left--;
                    if (payload_left == 0) phase = PH_HDR_FIRST;
                end
                default: ;
            endcase
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind %0d type %h data %h len %0d last %b",
                             got.kind, got.frame_type, got.payload_byte,
                             got.payload_length, got.last);
                return;
            end
            want = pending_words.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp kind %0d type %h data %h len %0d last %b, got kind %0d type %h data %h len %0d last %b",
                             want.kind, want.frame_type, want.payload_byte,
                             want.payload_length, want.last, got.kind, got.frame_type,
                             got.payload_byte, got.payload_length, got.last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr;
    logic [19:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    varint_length_frame_deframer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr(i_cfg_wr), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    frame_scoreboard sb;
    logic [7:0] byte_stream[$];
    int  idle_pct_tx = 24;
    int  idle_pct_rx = 24;
    int  holdoff_cycles = 0;
    int  quiet_cycles = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random backpressure plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (holdoff_cycles > 0) begin
            holdoff_cycles <= holdoff_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct_rx);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.frame_type = m_axis_tdata[7:0];
            got.payload_byte = m_axis_tdata[15:8];
            got.payload_length = m_axis_tdata[35:16];
            got.last = m_axis_tlast;
            sb.check_word(got);
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("FAIL varint_length_frame_deframer");
            $finish;
        end
    end

    task automatic send_stream();
        while (byte_stream.size() > 0) begin
            if ($urandom_range(99) < idle_pct_tx) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= byte_stream[0];
                @(posedge i_clk);
                while (!s_axis_tready) @(posedge i_clk);
                sb.note_byte(byte_stream.pop_front());
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_words.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [19:0] value);
        i_cfg_wr <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_wr <= 1'b0;
        sb.max_frame = value;
    endtask

    // queue one frame; hdr_bytes is 1, 2, 4 or 8
    task automatic add_frame(int hdr_bytes, longint unsigned len, logic [7:0] ftype,
                             bit with_payload);
        logic [1:0] prefix;
        prefix = (hdr_bytes == 1) ? 2'd0 : (hdr_bytes == 2) ? 2'd1 :
                 (hdr_bytes == 4) ? 2'd2 : 2'd3;
        for (int i = hdr_bytes - 1; i >= 0; i--) begin
            logic [7:0] b;
            b = 8'(len >> (8 * i));
            if (i == hdr_bytes - 1) b[7:6] = prefix;
            byte_stream.push_back(b);
        end
        byte_stream.push_back(ftype);
        if (with_payload)
            for (longint unsigned k = 0; k < len; k++)
                byte_stream.push_back(8'($urandom));
    endtask

    task automatic add_random_frames(int budget, logic [19:0] limit);
        while (byte_stream.size() < budget) begin
            int hb;
            longint unsigned len;
            int sel;
            sel = $urandom_range(3);
            hb = 1 << sel;
            if ($urandom_range(9) == 0) len = $urandom_range(0, 2);
            else len = $urandom_range(0, 20);
            if (hb == 1 && len > 63) len = 63;
            if (len + hb + 1 > limit) len = 0;
            if (len + hb + 1 > limit) hb = 1;
            add_frame(hb, len, 8'($urandom), 1);
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        i_rst_n = 1'b0;
        i_cfg_wr = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each header size, empty frames, extreme bytes
        add_frame(1, 0, 8'h00, 1);
        add_frame(1, 1, 8'hFF, 1);
        byte_stream.push_back(8'h00);
        byte_stream.push_back(8'hFF);
        byte_stream.push_back(8'h01);
        byte_stream.push_back(8'hAA);
        byte_stream.push_back(8'h55);
        add_frame(2, 2, 8'h5A, 1);
        add_frame(4, 1, 8'hA5, 1);
        add_frame(8, 0, 8'h81, 1);
        send_stream();
        drain();

        write_limit(20'hFFFFF);
        idle_pct_tx = 0;
        idle_pct_rx = 0;
        add_random_frames(150, 20'hFFFFF);
        send_stream();
        drain();

        idle_pct_tx = 24;
        idle_pct_rx = 24;
        write_limit(20'd40);
        holdoff_cycles <= 60;
        add_random_frames(300, 20'd40);
        send_stream();
        drain();

        // smallest legal limit: only single-byte empty frames fit
        write_limit(20'd2);
        for (int i = 0; i < 20; i++) add_frame(1, 0, 8'($urandom), 1);
        send_stream();
        drain();

        write_limit(20'd300);
        add_random_frames(420, 20'd300);
        // end with an oversize frame; everything after it is dropped
        add_frame(8, 64'h3FFF_FFFF_FFFF_FFFF, 8'h00, 0);
        for (int i = 0; i < 20; i++) byte_stream.push_back(8'($urandom));
        send_stream();
        drain();

        if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
            $display("PASS varint_length_frame_deframer");
        end else begin
            $display("FAIL varint_length_frame_deframer");
        end
        $finish;
    end
endmodule
